@@ rtl/core/ps2mc_pkg.sv @@
// types and constants shared by the ps2 mouse packet cursor block
`timescale 1ns / 1ps
`default_nettype none

package ps2mc_pkg;

  localparam int unsigned LimitW  = 12;
  localparam int unsigned OutPosW = 12;
  localparam int unsigned BtnW    = 3;

  // configuration register indexes
  typedef enum logic {
    REG_X_LIMIT = 1'b0,
    REG_Y_LIMIT = 1'b1
  } reg_index_t;

  // where the next mouse byte falls in a packet
  typedef enum logic [1:0] {
    PH_HEAD   = 2'd0,
    PH_XDELTA = 2'd1,
    PH_YDELTA = 2'd2
  } phase_t;

  // head byte bits
  localparam int unsigned HeadSyncBit  = 3;
  localparam int unsigned HeadXSignBit = 4;
  localparam int unsigned HeadYSignBit = 5;
  localparam int unsigned BtnLeft      = 0;
  localparam int unsigned BtnRight     = 1;

  localparam logic [LimitW-1:0] XLimitReset = 12'd319;
  localparam logic [LimitW-1:0] YLimitReset = 12'd199;

endpackage

`default_nettype wire

@@ rtl/core/ps2_mouse_packet_cursor_core.sv @@
// ps2 mouse packet decoder with clamped cursor, top level
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | rx_byte, from_aux
//  out     | out_valid/ out_ready | packet_done, sync_drop, cursor_x, cursor_y,
//          |                      | button_bits, left_click, right_click
//  cfg     | cfg_write            | cfg_index, cfg_data (no wait, no read-back)
//
// one beat in gives one beat out in the next cycle; a beat every cycle while out_ready is high.
// packet state and cursor update at input accept, the result lands in the
// output register. in_ready follows the output register: it drops only
// while a result is held and out_ready is low.
// rst (synchronous) restores limits 319/199, cursor 160/100, phase head.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_cursor_core
  import ps2mc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                from_aux,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     packet_done,
  output logic                     sync_drop,
  output logic [OutPosW-1:0]       cursor_x,
  output logic [OutPosW-1:0]       cursor_y,
  output logic [BtnW-1:0]          button_bits,
  output logic                     left_click,
  output logic                     right_click,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [LimitW-1:0]   cfg_data
);

  localparam int unsigned PosW  = (COORD_BITS < OutPosW) ? COORD_BITS : OutPosW;
  localparam int unsigned SumW  = PosW + 2;
  localparam logic [LimitW-1:0] BoundCap = (COORD_BITS >= LimitW) ?
                                           {LimitW{1'b1}} :
                                           LimitW'((1 << COORD_BITS) - 1);
  localparam logic [PosW-1:0] PosXReset = PosW'(160);
  localparam logic [PosW-1:0] PosYReset = PosW'(100);

  function automatic logic [PosW-1:0] bound_of(input logic [LimitW-1:0] lim);
    logic [LimitW-1:0] b;
    b = (lim > BoundCap) ? BoundCap : lim;
    return PosW'(b);
  endfunction

  function automatic logic [PosW-1:0] clamp_sum(input logic signed [SumW-1:0] s,
                                                input logic [PosW-1:0] b);
    logic [PosW-1:0] r;
    if (s < 0) begin
      r = '0;
    end else if (s > $signed({2'b00, b})) begin
      r = b;
    end else begin
      r = s[PosW-1:0];
    end
    return r;
  endfunction

  logic [LimitW-1:0] x_limit, x_limit_next;
  logic [LimitW-1:0] y_limit, y_limit_next;
  phase_t            byte_phase, byte_phase_next;
  logic [7:0]        head_byte, head_byte_next;
  logic [7:0]        x_delta_byte, x_delta_byte_next;
  logic [PosW-1:0]   pos_x, pos_x_next;
  logic [PosW-1:0]   pos_y, pos_y_next;
  logic [BtnW-1:0]   held_buttons, held_buttons_next;
  logic [BtnW-1:0]   last_buttons, last_buttons_next;
  logic              done_next, drop_next;

  logic                   in_fire;
  logic signed [8:0]      dx, dy;
  logic signed [SumW-1:0] sum_x, sum_y;
  logic [PosW-1:0]        bound_x, bound_y, cfg_bound;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign dx      = {head_byte[HeadXSignBit], x_delta_byte};
  assign dy      = {head_byte[HeadYSignBit], rx_byte};
  assign sum_x   = $signed({2'b00, pos_x}) + SumW'(dx);
  assign sum_y   = $signed({2'b00, pos_y}) - SumW'(dy);
  assign bound_x = bound_of(x_limit);
  assign bound_y = bound_of(y_limit);
  assign cfg_bound = bound_of(cfg_data);

  // packet assembly, cursor update and limit register writes
  always_comb begin
    byte_phase_next   = byte_phase;
    head_byte_next    = head_byte;
    x_delta_byte_next = x_delta_byte;
    pos_x_next        = pos_x;
    pos_y_next        = pos_y;
    held_buttons_next = held_buttons;
    last_buttons_next = last_buttons;
    x_limit_next      = x_limit;
    y_limit_next      = y_limit;
    done_next         = 1'b0;
    drop_next         = 1'b0;
    if (in_fire && from_aux) begin
      case (byte_phase)
        PH_XDELTA: begin
          x_delta_byte_next = rx_byte;
          byte_phase_next   = PH_YDELTA;
        end
        PH_YDELTA: begin
          last_buttons_next = held_buttons;
          held_buttons_next = head_byte[BtnW-1:0];
          pos_x_next        = clamp_sum(sum_x, bound_x);
          pos_y_next        = clamp_sum(sum_y, bound_y);
          byte_phase_next   = PH_HEAD;
          done_next         = 1'b1;
        end
        default: begin
          if (rx_byte[HeadSyncBit]) begin
            head_byte_next  = rx_byte;
            byte_phase_next = PH_XDELTA;
          end else begin
            byte_phase_next = PH_HEAD;
            drop_next       = 1'b1;
          end
        end
      endcase
    end
    if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_X_LIMIT: begin
          x_limit_next = cfg_data;
          if (pos_x_next > cfg_bound) begin
            pos_x_next = cfg_bound;
          end
        end
        REG_Y_LIMIT: begin
          y_limit_next = cfg_data;
          if (pos_y_next > cfg_bound) begin
            pos_y_next = cfg_bound;
          end
        end
        default: begin
          x_limit_next = x_limit;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase <= PH_HEAD;
    end else begin
      byte_phase <= byte_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit      <= XLimitReset;
      y_limit      <= YLimitReset;
      head_byte    <= '0;
      x_delta_byte <= '0;
      pos_x        <= PosXReset;
      pos_y        <= PosYReset;
      held_buttons <= '0;
      last_buttons <= '0;
    end else begin
      x_limit      <= x_limit_next;
      y_limit      <= y_limit_next;
      head_byte    <= head_byte_next;
      x_delta_byte <= x_delta_byte_next;
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      held_buttons <= held_buttons_next;
      last_buttons <= last_buttons_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      packet_done <= done_next;
      sync_drop   <= drop_next;
      cursor_x    <= OutPosW'(pos_x_next);
      cursor_y    <= OutPosW'(pos_y_next);
      button_bits <= held_buttons_next;
      left_click  <= held_buttons_next[BtnLeft] && !last_buttons_next[BtnLeft];
      right_click <= held_buttons_next[BtnRight] && !last_buttons_next[BtnRight];
    end
  end

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(packet_done && sync_drop))
    else $error("packet_done and sync_drop together");

  a_pos_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (pos_x <= bound_x) && (pos_y <= bound_y))
    else $error("cursor outside its bound");

  a_third_byte_done: assert property (@(posedge clk) disable iff (rst)
    (in_fire && from_aux && byte_phase == PH_YDELTA) |=> (out_valid && packet_done))
    else $error("third mouse byte did not complete a packet");

endmodule

`default_nettype wire

@@ tb/ps2_mouse_packet_cursor_core_test.sv @@
// self-checking testbench for the ps2 mouse packet cursor core
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_core_test;
  import ps2mc_pkg::*;

  localparam int CoordBits   = 12;
  localparam int CoordMax    = (1 << CoordBits) - 1;
  localparam int CycleLimit  = 200000;
  localparam int RandomBytes = 60;

  typedef struct packed {
    logic               packet_done;
    logic               sync_drop;
    logic [OutPosW-1:0] cursor_x;
    logic [OutPosW-1:0] cursor_y;
    logic [BtnW-1:0]    button_bits;
    logic               left_click;
    logic               right_click;
  } cursor_beat_t;

  class cursor_scoreboard;
    cursor_beat_t      expected_q[$];
    logic [LimitW-1:0] x_lim;
    logic [LimitW-1:0] y_lim;
    phase_t            phase;
    logic [7:0]        head;
    logic [7:0]        x_byte;
    int                pos_x;
    int                pos_y;
    logic [BtnW-1:0]   held;
    logic [BtnW-1:0]   prev_held;
    int                errors;

    function new();
      x_lim     = XLimitReset;
      y_lim     = YLimitReset;
      phase     = PH_HEAD;
      head      = 8'h00;
      x_byte    = 8'h00;
      pos_x     = 160;
      pos_y     = 100;
      held      = '0;
      prev_held = '0;
      errors    = 0;
    endfunction

    function int clamp_axis(int v, logic [LimitW-1:0] lim);
      int bound;
      bound = (int'(lim) > CoordMax) ? CoordMax : int'(lim);
      if (v < 0) v = 0;
      if (v > bound) v = bound;
      return v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // a limit write also pulls the stored position inside the new bound
    function void apply_limit(reg_index_t idx, logic [LimitW-1:0] v);
      if (idx == REG_X_LIMIT) begin
        x_lim = v;
        pos_x = clamp_axis(pos_x, x_lim);
      end else begin
        y_lim = v;
        pos_y = clamp_axis(pos_y, y_lim);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic aux);
      cursor_beat_t want;
      int dx;
      int dy;
      want = '0;
      if (aux) begin
        case (phase)
          PH_XDELTA: begin
            x_byte = b;
            phase  = PH_YDELTA;
          end
          PH_YDELTA: begin
            dx = int'(x_byte) - (head[HeadXSignBit] ? 256 : 0);
            dy = int'(b) - (head[HeadYSignBit] ? 256 : 0);
            prev_held = held;
            held      = head[BtnW-1:0];
            pos_x     = clamp_axis(pos_x + dx, x_lim);
            pos_y     = clamp_axis(pos_y - dy, y_lim);
            phase     = PH_HEAD;
            want.packet_done = 1'b1;
          end
          default: begin
            if (b[HeadSyncBit]) begin
              head  = b;
              phase = PH_XDELTA;
            end else begin
              phase = PH_HEAD;
              want.sync_drop = 1'b1;
            end
          end
        endcase
      end
      want.cursor_x    = pos_x[OutPosW-1:0];
      want.cursor_y    = pos_y[OutPosW-1:0];
      want.button_bits = held;
      want.left_click  = held[BtnLeft] && !prev_held[BtnLeft];
      want.right_click = held[BtnRight] && !prev_held[BtnRight];
      expected_q.push_back(want);
    endfunction

    task report(string field, int got, int want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      errors++;
    endtask

    task check_beat(cursor_beat_t got);
      cursor_beat_t want;
      if (expected_q.size() == 0) begin
        report("unexpected beat, cursor_x", got.cursor_x, -1);
      end else begin
        want = expected_q.pop_front();
        if (got.packet_done !== want.packet_done)
          report("packet_done", got.packet_done, want.packet_done);
        if (got.sync_drop !== want.sync_drop)
          report("sync_drop", got.sync_drop, want.sync_drop);
        if (got.cursor_x !== want.cursor_x)
          report("cursor_x", got.cursor_x, want.cursor_x);
        if (got.cursor_y !== want.cursor_y)
          report("cursor_y", got.cursor_y, want.cursor_y);
        if (got.button_bits !== want.button_bits)
          report("button_bits", got.button_bits, want.button_bits);
        if (got.left_click !== want.left_click)
          report("left_click", got.left_click, want.left_click);
        if (got.right_click !== want.right_click)
          report("right_click", got.right_click, want.right_click);
      end
    endtask
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic [7:0]        rx_byte   = 8'h00;
  logic              from_aux  = 1'b0;
  logic              out_ready = 1'b1;
  logic              cfg_write = 1'b0;
  logic              cfg_index = 1'b0;
  logic [LimitW-1:0] cfg_data  = '0;

  logic               in_ready;
  logic               out_valid;
  logic               packet_done;
  logic               sync_drop;
  logic [OutPosW-1:0] cursor_x;
  logic [OutPosW-1:0] cursor_y;
  logic [BtnW-1:0]    button_bits;
  logic               left_click;
  logic               right_click;

  bit               in_idle  = 1'b0;
  bit               out_idle = 1'b0;
  int               cycles;
  cursor_scoreboard sb;

  ps2_mouse_packet_cursor_core #(
    .COORD_BITS(CoordBits)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .from_aux   (from_aux),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .packet_done(packet_done),
    .sync_drop  (sync_drop),
    .cursor_x   (cursor_x),
    .cursor_y   (cursor_y),
    .button_bits(button_bits),
    .left_click (left_click),
    .right_click(right_click),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin : beat_monitor
    cursor_beat_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {packet_done, sync_drop, cursor_x, cursor_y, button_bits,
               left_click, right_click};
        sb.check_beat(got);
      end
      if (in_valid && in_ready) sb.note_byte(rx_byte, from_aux);
    end
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (out_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("ps2_mouse_packet_cursor_core_test NOT OK");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic aux);
    if (in_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    from_aux <= aux;
    do @(posedge clk); while (!in_ready);
  endtask

  // the edge first, so the last accepted beat is already in the queue
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limits(input logic [LimitW-1:0] x, input logic [LimitW-1:0] y);
    cfg_write <= 1'b1;
    cfg_index <= REG_X_LIMIT;
    cfg_data  <= x;
    @(posedge clk);
    sb.apply_limit(REG_X_LIMIT, x);
    cfg_index <= REG_Y_LIMIT;
    cfg_data  <= y;
    @(posedge clk);
    sb.apply_limit(REG_Y_LIMIT, y);
    cfg_write <= 1'b0;
  endtask

  // half full-range deltas, half small moves of either sign
  function automatic logic [7:0] rand_delta();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(248, 255));
  endfunction

  task automatic maybe_stray();
    if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // mostly well-formed packets, with noise, bad heads and cut-off packets
  task automatic run_mix(input int n);
    int         sent;
    int         kind;
    logic       aux;
    logic [7:0] head;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        aux = 1'($urandom_range(0, 1));
        send_byte(8'($urandom_range(0, 255)), aux);
        if (aux) sent++;
      end else if (kind == 1) begin
        send_byte(8'($urandom_range(0, 255)) & 8'hF7, 1'b1);
        sent++;
      end else begin
        head = 8'($urandom_range(0, 255)) | 8'h08;
        send_byte(head, 1'b1);
        maybe_stray();
        send_byte(rand_delta(), 1'b1);
        sent += 2;
        if (kind != 2) begin
          maybe_stray();
          send_byte(rand_delta(), 1'b1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [LimitW-1:0] x_set[5];
    logic [LimitW-1:0] y_set[5];
    sb = new();
    x_set = '{12'd0, 12'd4095, 12'd1, 12'($urandom_range(0, 4095)), 12'd319};
    y_set = '{12'd0, 12'd4095, 12'd2, 12'($urandom_range(0, 4095)), 12'd199};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // stray bytes, dropped heads, then packets across the delta and button extremes
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hF7, 1'b1);
    send_byte(8'h08, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h09, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h0B, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h3F, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h08, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);

    in_idle  = 1'b1;
    out_idle = 1'b1;
    run_mix(RandomBytes);

    for (int i = 0; i < 5; i++) begin
      drain();
      write_limits(x_set[i], y_set[i]);
      in_idle  = (i < 4) && ($urandom_range(0, 3) != 0);
      out_idle = (i < 4) && ($urandom_range(0, 3) != 0);
      run_mix(RandomBytes);
    end

    drain();
    if (sb.errors == 0) begin
      $display("ps2_mouse_packet_cursor_core_test OK");
    end else begin
      $display("ps2_mouse_packet_cursor_core_test NOT OK");
    end
    $finish;
  end

endmodule

@@ ps2_mouse_packet_cursor_core.f @@
rtl/core/ps2mc_pkg.sv
rtl/core/ps2_mouse_packet_cursor_core.sv
tb/ps2_mouse_packet_cursor_core_test.sv
